// ===== hw/rtl/jsu_pkg.sv =====
// Shared types, character codes and decode helpers for the JSON string unescaper.
// No dependencies; used by json_string_unescaper_core.
`default_nettype none

package jsu_pkg;

  // Decoder mode, one-hot
  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX     = 6'b000100,
    MODE_WANT_BS = 6'b001000,
    MODE_WANT_U  = 6'b010000,
    MODE_TRAIL   = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Top six bits of a UTF-16 lead / trail surrogate
  localparam logic [5:0] LEAD_TAG  = 6'b110110;
  localparam logic [5:0] TRAIL_TAG = 6'b110111;

  localparam int unsigned MAX_BEATS = 4;
  localparam int unsigned CNT_W     = $clog2(MAX_BEATS + 1);

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Up to four UTF-8 bytes, first byte in the top lane
  typedef struct packed {
    logic [8*MAX_BEATS-1:0] bytes;
    logic [CNT_W-1:0]       cnt;
  } utf8_t;

  // Result group waiting on the output channel
  typedef struct packed {
    logic [8*MAX_BEATS-1:0] bytes;
    logic [CNT_W-1:0]       rem;
    logic                   eos;
    logic                   fail;
  } grp_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    u.cnt   = CNT_W'(0);
    if (cp == 21'd0) begin
      u.cnt = CNT_W'(0);
    end else if (cp[20:7] == 14'd0) begin
      u.cnt   = CNT_W'(1);
      u.bytes = {cp[7:0], 24'd0};
    end else if (cp[20:11] == 10'd0) begin
      u.cnt   = CNT_W'(2);
      u.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
    end else if (cp[20:16] == 5'd0) begin
      u.cnt   = CNT_W'(3);
      u.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
    end else begin
      u.cnt   = CNT_W'(4);
      u.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_unescaper_core.sv =====
// JSON string body unescaper: escaped bytes in, UTF-8 bytes plus end beat out.
// Depends on jsu_pkg (mode type, character codes, hex and UTF-8 helpers).
//
// Usage:
//   Input channel (in_valid / in_stall / in_byte) carries the string body one
//   byte per beat; a zero byte terminates the string. Output channel
//   (out_valid / out_stall / out_*) carries decoded UTF-8 bytes, then a single
//   end beat with out_byte = 0, out_end_of_string = 1 and out_failed set if
//   the string was malformed. Bytes that decode to nothing (backslash, hex
//   digits, a \u0000 escape, anything after an error) give no beat.
// Timing:
//   An accepted byte waits in the input register, is decoded from there
//   and lands in the result register, which drives its first output beat.
//   Throughput is one byte per cycle while each byte yields at most one beat
//   and the receiver does not stall. A \u escape that yields more than one
//   UTF-8 byte holds the result register until its last byte leaves, and
//   the input side stalls meanwhile; the input register still takes one
//   byte during that time.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to plain mode with no error. When the receiver stalls, the current
// beat holds, the result group does not drain and the input backs up after
// one buffered byte.
`default_nettype none

module json_string_unescaper_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte,
  output      logic       out_end_of_string,
  output      logic       out_failed
);

  localparam int unsigned BW = 8 * jsu_pkg::MAX_BEATS;

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;

  // Decoder state
  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     dig_r, dig_nxt;   // hex digit index within a code unit
  logic [11:0]    code_r, code_nxt; // hex digits collected so far (first three)
  logic [9:0]     lead_r, lead_nxt; // low bits of a pending lead surrogate
  logic           err_r, err_nxt;

  // Result register
  jsu_pkg::grp_t grp_r, grp_nxt;
  jsu_pkg::grp_t dec_grp;           // what this byte produces

  logic in_acc, out_pop, grp_free, advance;

  // Decode scratch
  jsu_pkg::hex_t  hx;
  jsu_pkg::utf8_t enc;
  logic [15:0]    unit_new;
  logic [20:0]    cp_pair;
  logic           do_fail;

  assign out_valid         = (grp_r.rem != '0);
  assign out_byte          = grp_r.bytes[BW-1 -: 8];
  assign out_end_of_string = grp_r.eos;
  assign out_failed        = grp_r.fail;

  assign out_pop  = out_valid && !out_stall;
  // Result register frees when empty or when its last beat leaves now
  assign grp_free = !out_valid || (out_pop && grp_r.rem == jsu_pkg::CNT_W'(1));
  assign advance  = in_vld_r && grp_free;
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  assign hx       = jsu_pkg::hex_decode(in_byte_r);
  assign unit_new = {code_r, hx.val};
  // Supplementary code point from a surrogate pair
  assign cp_pair  = 21'h10000 + {1'b0, lead_r, unit_new[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    dig_nxt  = dig_r;
    code_nxt = code_r;
    lead_nxt = lead_r;
    err_nxt  = err_r;
    do_fail  = 1'b0;
    enc      = '0;
    dec_grp  = '0;

    if (in_byte_r == jsu_pkg::CH_NUL) begin
      // Terminator: one end beat, then back to reset state
      dec_grp.rem  = jsu_pkg::CNT_W'(1);
      dec_grp.eos  = 1'b1;
      dec_grp.fail = err_r || (mode_r != jsu_pkg::MODE_PLAIN);
      mode_nxt     = jsu_pkg::MODE_PLAIN;
      dig_nxt      = 2'd0;
      code_nxt     = 12'd0;
      lead_nxt     = 10'd0;
      err_nxt      = 1'b0;
    end else if (!err_r) begin
      unique case (mode_r)
        jsu_pkg::MODE_PLAIN: begin
          if (in_byte_r == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            dec_grp.rem   = jsu_pkg::CNT_W'(1);
            dec_grp.bytes = {in_byte_r, 24'd0};
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_nxt    = jsu_pkg::MODE_PLAIN;
          dec_grp.rem = jsu_pkg::CNT_W'(1);
          case (in_byte_r) inside
            jsu_pkg::CH_QUOTE,
            jsu_pkg::CH_BSLASH,
            jsu_pkg::CH_SLASH: dec_grp.bytes = {in_byte_r, 24'd0};
            jsu_pkg::CH_B:     dec_grp.bytes = {8'h08, 24'd0};
            jsu_pkg::CH_F:     dec_grp.bytes = {8'h0C, 24'd0};
            jsu_pkg::CH_N:     dec_grp.bytes = {8'h0A, 24'd0};
            jsu_pkg::CH_R:     dec_grp.bytes = {8'h0D, 24'd0};
            jsu_pkg::CH_T:     dec_grp.bytes = {8'h09, 24'd0};
            jsu_pkg::CH_U: begin
              dec_grp.rem = '0;
              mode_nxt    = jsu_pkg::MODE_HEX;
              dig_nxt     = 2'd0;
              code_nxt    = 12'd0;
            end
            default: begin
              dec_grp.rem = '0;
              do_fail     = 1'b1;
            end
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          if (!hx.ok) begin
            do_fail = 1'b1;
          end else if (dig_r != 2'd3) begin
            dig_nxt  = dig_r + 2'd1;
            code_nxt = unit_new[11:0];
          end else if (unit_new[15:10] == jsu_pkg::LEAD_TAG) begin
            lead_nxt = unit_new[9:0];
            code_nxt = 12'd0;
            mode_nxt = jsu_pkg::MODE_WANT_BS;
          end else if (unit_new[15:10] == jsu_pkg::TRAIL_TAG) begin
            do_fail = 1'b1;
          end else begin
            enc           = jsu_pkg::utf8_encode({5'd0, unit_new});
            dec_grp.rem   = enc.cnt;
            dec_grp.bytes = enc.bytes;
            mode_nxt      = jsu_pkg::MODE_PLAIN;
            code_nxt      = 12'd0;
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (in_byte_r == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_WANT_U;
          end else begin
            do_fail = 1'b1;
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (in_byte_r == jsu_pkg::CH_U) begin
            mode_nxt = jsu_pkg::MODE_TRAIL;
            dig_nxt  = 2'd0;
            code_nxt = 12'd0;
          end else begin
            do_fail = 1'b1;
          end
        end
        jsu_pkg::MODE_TRAIL: begin
          if (!hx.ok) begin
            do_fail = 1'b1;
          end else if (dig_r != 2'd3) begin
            dig_nxt  = dig_r + 2'd1;
            code_nxt = unit_new[11:0];
          end else if (unit_new[15:10] != jsu_pkg::TRAIL_TAG) begin
            do_fail = 1'b1;
          end else begin
            enc           = jsu_pkg::utf8_encode(cp_pair);
            dec_grp.rem   = enc.cnt;
            dec_grp.bytes = enc.bytes;
            mode_nxt      = jsu_pkg::MODE_PLAIN;
            code_nxt      = 12'd0;
            lead_nxt      = 10'd0;
          end
        end
        default: begin
          mode_nxt = jsu_pkg::MODE_PLAIN;
        end
      endcase

      if (do_fail) begin
        // Malformed: latch error, drop to plain, swallow bytes until the end
        err_nxt  = 1'b1;
        mode_nxt = jsu_pkg::MODE_PLAIN;
        dig_nxt  = 2'd0;
        code_nxt = 12'd0;
        lead_nxt = 10'd0;
      end
    end
  end

  // Result register: load a fresh group or shift out one beat
  always_comb begin
    grp_nxt = grp_r;
    if (advance && dec_grp.rem != '0) begin
      grp_nxt = dec_grp;
    end else if (out_pop) begin
      grp_nxt.rem   = grp_r.rem - jsu_pkg::CNT_W'(1);
      grp_nxt.bytes = {grp_r.bytes[BW-9:0], 8'd0};
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= jsu_pkg::MODE_PLAIN;
      dig_r    <= 2'd0;
      err_r    <= 1'b0;
      grp_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      grp_r    <= grp_nxt;
      if (advance) begin
        mode_r <= mode_nxt;
        dig_r  <= dig_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_byte;
    end
    if (advance) begin
      code_r <= code_nxt;
      lead_r <= lead_nxt;
    end
  end

`ifndef SYNTHESIS
  // Error state always sits in plain mode
  a_err_plain: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (mode_r == jsu_pkg::MODE_PLAIN))
    else $error("error flag set outside plain mode");

  // End beat is a lone zero byte
  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_string) |->
      (out_byte == 8'd0 && grp_r.rem == jsu_pkg::CNT_W'(1)))
    else $error("malformed end beat");

  // A terminator leaves the decoder clean
  a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_byte_r == jsu_pkg::CH_NUL) |=>
      (!err_r && mode_r == jsu_pkg::MODE_PLAIN))
    else $error("state not cleared after terminator");

  // Result group never exceeds four beats
  a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r.rem <= jsu_pkg::CNT_W'(jsu_pkg::MAX_BEATS))
    else $error("result group overflow");
`endif

endmodule

`default_nettype wire
